// ===== hw/rtl/flvtd_pkg.sv =====
// Shared types, codes and constants of the FLV tag demultiplexer.
`default_nettype none
package flvtd_pkg;

  typedef enum logic [2:0] {
    PhHeader,
    PhSkip,
    PhPrev,
    PhTagHdr,
    PhPayload,
    PhDone
  } phase_e;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusTrunc  = 2'd1;
  localparam logic [1:0] StatusBadSig = 2'd2;

  localparam logic KindPayload = 1'b0;
  localparam logic KindStatus  = 1'b1;

  localparam logic [1:0] ClassAudio  = 2'd0;
  localparam logic [1:0] ClassVideo  = 2'd1;
  localparam logic [1:0] ClassScript = 2'd2;
  localparam logic [1:0] ClassOther  = 2'd3;

  localparam logic [7:0] TypeAudio  = 8'd8;
  localparam logic [7:0] TypeVideo  = 8'd9;
  localparam logic [7:0] TypeScript = 8'd18;

  localparam logic [31:0] HeaderLen  = 32'd9;
  localparam logic [23:0] PrevLen    = 24'd4;
  localparam logic [23:0] TagHdrLen  = 24'd11;

  typedef struct packed {
    logic        item_kind;
    logic [1:0]  tag_class;
    logic [7:0]  tag_type_raw;
    logic [23:0] tag_number;
    logic [7:0]  payload_byte;
    logic        first_of_tag;
    logic        last_of_tag;
    logic [23:0] payload_size;
    logic [31:0] time_stamp;
    logic [1:0]  status;
    logic        stream_done;
  } result_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    case (idx)
      2'd0:    sig_byte = 8'h46;
      2'd1:    sig_byte = 8'h4C;
      default: sig_byte = 8'h56;
    endcase
  endfunction

  function automatic logic [1:0] class_of(input logic [7:0] t);
    case (t)
      TypeAudio:  class_of = ClassAudio;
      TypeVideo:  class_of = ClassVideo;
      TypeScript: class_of = ClassScript;
      default:    class_of = ClassOther;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/flvtd_parse.sv =====
// Parser state and single-pass next-state / result logic, one byte per step.
`default_nettype none
module flvtd_parse import flvtd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  data_i,
  input  wire logic        eos_i,
  output logic             res_vld_o,
  output result_t          res_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [23:0] fcnt_q, fcnt_d;
  logic [31:0] off_q, off_d;
  logic [7:0]  type_q, type_d;
  logic [23:0] size_q, size_d;
  logic [31:0] time_q, time_d;
  logic [23:0] tags_q, tags_d;
  logic        sig_bad_q, sig_bad_d;

  logic        fin;
  logic [1:0]  fin_status;
  logic        pay_vld;
  logic        pay_first, pay_last;
  logic [1:0]  pay_status;
  logic [23:0] fcnt_inc;
  logic [31:0] pos_inc;
  logic [31:0] off_shift;

  assign fcnt_inc  = fcnt_q + 24'd1;
  assign pos_inc   = pos_q + 32'd1;
  assign off_shift = {off_q[23:0], data_i};

  // next-state logic
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    fcnt_d     = fcnt_q;
    off_d      = off_q;
    type_d     = type_q;
    size_d     = size_q;
    time_d     = time_q;
    tags_d     = tags_q;
    sig_bad_d  = sig_bad_q;
    fin        = 1'b0;
    fin_status = StatusOk;
    pay_vld    = 1'b0;
    pay_first  = (fcnt_q == 24'd0);
    pay_last   = ({1'b0, fcnt_q} + 25'd1) >= {1'b0, size_q};
    pay_status = StatusOk;

    case (phase_q)
      PhHeader: begin
        pos_d = pos_inc;
        if (pos_q < 32'd3 && data_i != sig_byte(pos_q[1:0])) sig_bad_d = 1'b1;
        if (pos_q >= 32'd5) off_d = off_shift;
        if (pos_q >= HeaderLen - 32'd1) begin
          if (sig_bad_q) begin
            fin        = 1'b1;
            fin_status = StatusBadSig;
          end else begin
            // no seeking back: a short offset means data starts right here
            if (off_shift < HeaderLen) off_d = HeaderLen;
            if (eos_i) begin
              fin        = 1'b1;
              fin_status = StatusOk;
            end else begin
              fcnt_d  = '0;
              phase_d = (off_shift <= HeaderLen) ? PhPrev : PhSkip;
            end
          end
        end else if (eos_i) begin
          fin        = 1'b1;
          fin_status = StatusTrunc;
        end
      end
      PhSkip: begin
        pos_d = pos_inc;
        if (eos_i) begin
          fin        = 1'b1;
          fin_status = StatusOk;
        end else if (pos_inc == off_q) begin
          phase_d = PhPrev;
          fcnt_d  = '0;
        end
      end
      PhPrev: begin
        fcnt_d = fcnt_inc;
        if (eos_i) begin
          fin        = 1'b1;
          fin_status = StatusOk;
        end else if (fcnt_inc >= PrevLen) begin
          phase_d = PhTagHdr;
          fcnt_d  = '0;
        end
      end
      PhTagHdr: begin
        case (fcnt_q[3:0])
          4'd0:    type_d = data_i;
          4'd1:    size_d = {data_i, 16'h0000};
          4'd2:    size_d = {size_q[23:16], data_i, size_q[7:0]};
          4'd3:    size_d = {size_q[23:8], data_i};
          4'd4:    time_d = {8'h00, data_i, 16'h0000};
          4'd5:    time_d = {time_q[31:16], data_i, time_q[7:0]};
          4'd6:    time_d = {time_q[31:8], data_i};
          4'd7:    time_d = {data_i, time_q[23:0]};
          default: ;
        endcase
        fcnt_d = fcnt_inc;
        if (fcnt_inc >= TagHdrLen) begin
          if (size_q == 24'd0 || eos_i) begin
            fin        = 1'b1;
            fin_status = StatusTrunc;
          end else begin
            phase_d = PhPayload;
            fcnt_d  = '0;
          end
        end else if (eos_i) begin
          fin        = 1'b1;
          fin_status = StatusOk;
        end
      end
      PhPayload: begin
        pay_vld = 1'b1;
        fcnt_d  = fcnt_inc;
        if (eos_i) begin
          pay_status = pay_last ? StatusOk : StatusTrunc;
          phase_d    = PhDone;
        end
        if (pay_last) begin
          if (tags_q != '1) tags_d = tags_q + 24'd1;
          fcnt_d = '0;
          if (!eos_i) phase_d = PhPrev;
        end
      end
      default: ;  // done: bytes are taken and dropped
    endcase

    if (fin) phase_d = PhDone;
  end

  // result forming; the status report carries the tag fields as just updated
  always_comb begin
    res_vld_o          = fin || pay_vld;
    res_o.item_kind    = fin ? KindStatus : KindPayload;
    res_o.tag_class    = class_of(type_d);
    res_o.tag_type_raw = type_d;
    res_o.tag_number   = tags_q;
    res_o.payload_byte = fin ? 8'h00 : data_i;
    res_o.first_of_tag = !fin && pay_first;
    res_o.last_of_tag  = !fin && pay_last;
    res_o.payload_size = size_d;
    res_o.time_stamp   = time_d;
    res_o.status       = fin ? fin_status : pay_status;
    res_o.stream_done  = fin || eos_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      pos_q     <= '0;
      fcnt_q    <= '0;
      off_q     <= '0;
      type_q    <= '0;
      size_q    <= '0;
      time_q    <= '0;
      tags_q    <= '0;
      sig_bad_q <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      fcnt_q    <= fcnt_d;
      off_q     <= off_d;
      type_q    <= type_d;
      size_q    <= size_d;
      time_q    <= time_d;
      tags_q    <= tags_d;
      sig_bad_q <= sig_bad_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/flvtd_res_reg.sv =====
// Result register between the parser and the output channel.
`default_nettype none
module flvtd_res_reg import flvtd_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    load_i,
  input  wire result_t res_i,
  input  wire logic    ready_i,
  output logic         can_take_o,
  output logic         valid_o,
  output result_t      res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_take_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i)       valid_d = 1'b1;
    else if (ready_i) valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_i;
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

// ===== hw/rtl/flv_tag_demux.sv =====
// Top level of the FLV tag demultiplexer: input register, parser, result register.
`default_nettype none
// Takes an FLV file one byte per transfer and returns each tag payload byte
// with its tag description, or one final status report. A byte is taken in
// every clock cycle while the output side keeps up; a byte is held in the
// input register until the result register can take its result. Only a
// stalled output slows the input. Once parsing has ended, further bytes are
// still taken and dropped until reset.
module flv_tag_demux import flvtd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_stream_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             item_kind_o,
  output logic [1:0]       tag_class_o,
  output logic [7:0]       tag_type_raw_o,
  output logic [23:0]      tag_number_o,
  output logic [7:0]       payload_byte_o,
  output logic             first_of_tag_o,
  output logic             last_of_tag_o,
  output logic [23:0]      payload_size_o,
  output logic [31:0]      time_stamp_o,
  output logic [1:0]       status_o,
  output logic             stream_done_o
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] data_q;
  logic       eos_q;
  logic       step;
  logic       can_take;
  logic       res_vld;
  result_t    res;
  result_t    out_res;

  assign step       = in_vld_q && can_take;
  assign in_ready_o = !in_vld_q || step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) in_vld_d = 1'b1;
    else if (step)                in_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_byte_i;
      eos_q  <= end_of_stream_i;
    end
  end

  flvtd_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .data_i    (data_q),
    .eos_i     (eos_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  flvtd_res_reg u_res_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step && res_vld),
    .res_i      (res),
    .ready_i    (out_ready_i),
    .can_take_o (can_take),
    .valid_o    (out_valid_o),
    .res_o      (out_res)
  );

  assign item_kind_o    = out_res.item_kind;
  assign tag_class_o    = out_res.tag_class;
  assign tag_type_raw_o = out_res.tag_type_raw;
  assign tag_number_o   = out_res.tag_number;
  assign payload_byte_o = out_res.payload_byte;
  assign first_of_tag_o = out_res.first_of_tag;
  assign last_of_tag_o  = out_res.last_of_tag;
  assign payload_size_o = out_res.payload_size;
  assign time_stamp_o   = out_res.time_stamp;
  assign status_o       = out_res.status;
  assign stream_done_o  = out_res.stream_done;

  // nothing follows the final transfer
  a_done_is_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && stream_done_o |=> !out_valid_o)
    else $error("result after end of parsing");

  // a status report always ends parsing and never marks payload bytes
  a_status_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KindStatus |->
      stream_done_o && !first_of_tag_o && !last_of_tag_o && payload_byte_o == 8'h00)
    else $error("malformed status report");

  // a clean end inside a payload only happens on the tag's last byte
  a_clean_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KindPayload && stream_done_o && status_o == StatusOk
      |-> last_of_tag_o)
    else $error("clean end reported mid-payload");

endmodule
`default_nettype wire
